### rtl/weighted_sorted_priority_queue_top_macros.svh
// assertion macros used by the priority queue datapath
`ifndef WEIGHTED_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define WEIGHTED_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define WSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wspq check failed");

// next-cycle implication, checked out of reset
`define WSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wspq check failed");

`endif

### rtl/wspq_pkg.sv
// shared constants, codes and types of the weighted priority queue
package wspq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ELEM_W      = 32;
    localparam int GRADE_W     = 14;
    localparam int COURSE_W    = 8;
    localparam int KEY_W       = 23;
    localparam int PROD_W      = GRADE_W + COURSE_W;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 14;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 88;

    localparam logic [GRADE_W-1:0]  GRADE_LIMIT_RESET = GRADE_W'(1000);
    localparam logic [COURSE_W-1:0] TOTAL_RESET       = COURSE_W'(30);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRADE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL       = 1'b1;

    // operations
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // slot read address select
    localparam logic [1:0] RD_IDX    = 2'd0;
    localparam logic [1:0] RD_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_IDX_M2 = 2'd2;
    localparam logic [1:0] RD_IDX_P1 = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [COURSE_W-1:0] courses;
        logic [GRADE_W-1:0]  grade;
        logic [ELEM_W-1:0]   element;
    } t_entry;

    typedef struct packed {
        logic                capture;
        logic                status_load;
        logic [STATUS_W-1:0] status_code;
        logic                key_en;
        logic                idx_load_occ;
        logic                idx_load_one;
        logic                idx_dec;
        logic                idx_inc;
        logic [1:0]          rd_mode;
        logic                wr_en;
        logic                wr_new;
        logic                wr_down;
        logic                occ_inc;
        logic                occ_dec;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic key_less;
        logic deq_end;
    } t_sts;

endpackage

### rtl/weighted_sorted_priority_queue_top.sv
// Weighted sorted priority queue: bounded queue of entries kept in descending
// key order, key = grade * total course count + courses * highest grade, ties fifo.
// Input channel s_axis: tuser carries the operation (0 enqueue, 1 dequeue),
// tdata the element, grade and course count. One result leaves on m_axis for
// every input transfer: empty flag, count, the front entry, its key, status.
// The config port writes the highest grade (index 0) and total courses
// (index 1); write it only while no item is in flight.
// An enqueue computes the key, then walks down from the tail, passing one
// entry per step until its slot is found (0..occupancy entries passed); a
// dequeue shifts each remaining entry up one slot; a flagged full enqueue or
// empty dequeue goes straight to the result. Input ready returns in the cycle
// after the result is loaded, so no new item is taken before the last is done.
// The walk is bound by the single read and single write port of the slot
// memory, one slot moved per cycle.
// A finished result sits in the output register; a stalled receiver holds the
// next result in its final state until the register frees. Reset empties the
// queue and restores the registers to 1000 and 30; slot contents are not
// cleared, and no unwritten slot's data reaches a result.
module weighted_sorted_priority_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wspq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wspq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // element_value[31:0], grade_hundredths[45:32], courses_passed[53:46]
    input  logic [wspq_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // operation
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // queue_empty[0], entry_count[5:1], front_element[37:6], front_grade[51:38],
    // front_courses[59:52], front_priority_key[82:60], status[84:83]
    output logic [wspq_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);
    import wspq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    wspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_op     (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    wspq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

### rtl/wspq_datapath.sv
// slot memory, key arithmetic, counters and result register
`include "weighted_sorted_priority_queue_top_macros.svh"

module wspq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wspq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wspq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [wspq_pkg::IN_DATA_W-1:0]      i_in_data,
    input  wspq_pkg::t_cmd                      i_cmd,
    output wspq_pkg::t_sts                      o_sts,
    output logic [wspq_pkg::OUT_DATA_W-1:0]     o_out_data
);
    import wspq_pkg::*;

    logic [GRADE_W-1:0]    r_grade_limit;
    logic [COURSE_W-1:0]   r_total;
    logic [CNT_W-1:0]      r_occ;
    logic [CNT_W-1:0]      r_idx;
    logic [STATUS_W-1:0]   r_status;
    logic [ELEM_W-1:0]     r_elem;
    logic [GRADE_W-1:0]    r_grade;
    logic [COURSE_W-1:0]   r_courses;
    logic [KEY_W-1:0]      r_key;
    t_entry                r_rdata;
    t_entry                r_front;
    logic [OUT_DATA_W-1:0] r_out;

    t_entry mem [QUEUE_DEPTH];

    logic [ELEM_W-1:0]   w_in_elem;
    logic [GRADE_W-1:0]  w_in_grade;
    logic [COURSE_W-1:0] w_in_courses;
    logic [GRADE_W-1:0]  w_grade_sat;
    logic [COURSE_W-1:0] w_courses_sat;
    logic [PROD_W-1:0]   w_prod_grade;
    logic [PROD_W-1:0]   w_prod_courses;
    logic [CNT_W-1:0]    w_idx_m1;
    logic [CNT_W-1:0]    w_idx_m2;
    logic [CNT_W-1:0]    w_idx_p1;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [ADDR_W-1:0]   w_wr_addr;
    t_entry              w_new;
    t_entry              w_wdata;
    t_entry              w_res_front;
    logic                w_res_empty;

    assign w_in_elem    = i_in_data[ELEM_W-1:0];
    assign w_in_grade   = i_in_data[ELEM_W +: GRADE_W];
    assign w_in_courses = i_in_data[ELEM_W+GRADE_W +: COURSE_W];

    assign w_grade_sat   = (w_in_grade > r_grade_limit) ? r_grade_limit : w_in_grade;
    assign w_courses_sat = (w_in_courses > r_total) ? r_total : w_in_courses;

    assign w_prod_grade   = PROD_W'(r_grade) * PROD_W'(r_total);
    assign w_prod_courses = PROD_W'(r_courses) * PROD_W'(r_grade_limit);

    assign w_idx_m1 = r_idx - CNT_W'(1);
    assign w_idx_m2 = r_idx - CNT_W'(2);
    assign w_idx_p1 = r_idx + CNT_W'(1);

    always_comb begin
        case (i_cmd.rd_mode)
            RD_IDX:    w_rd_addr = r_idx[ADDR_W-1:0];
            RD_IDX_M1: w_rd_addr = w_idx_m1[ADDR_W-1:0];
            RD_IDX_M2: w_rd_addr = w_idx_m2[ADDR_W-1:0];
            RD_IDX_P1: w_rd_addr = w_idx_p1[ADDR_W-1:0];
            default:   w_rd_addr = r_idx[ADDR_W-1:0];
        endcase
    end

    assign w_wr_addr = i_cmd.wr_down ? w_idx_m1[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

    always_comb begin
        w_new.key     = r_key;
        w_new.courses = r_courses;
        w_new.grade   = r_grade;
        w_new.element = r_elem;
    end

    assign w_wdata = i_cmd.wr_new ? w_new : r_rdata;

    // slot store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[w_wr_addr] <= w_wdata;
        end
        r_rdata <= mem[w_rd_addr];
    end

    // copy of slot zero so the result never waits on the memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && (w_wr_addr == '0)) begin
            r_front <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grade_limit <= GRADE_LIMIT_RESET;
            r_total       <= TOTAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRADE_LIMIT: r_grade_limit <= i_cfg_wdata[GRADE_W-1:0];
                CFG_TOTAL:       r_total       <= i_cfg_wdata[COURSE_W-1:0];
                default:         r_total       <= r_total;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.occ_inc) begin
                r_occ <= r_occ + CNT_W'(1);
            end else if (i_cmd.occ_dec) begin
                r_occ <= r_occ - CNT_W'(1);
            end
            if (i_cmd.idx_load_occ) begin
                r_idx <= r_occ;
            end else if (i_cmd.idx_load_one) begin
                r_idx <= CNT_W'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= w_idx_m1;
            end else if (i_cmd.idx_inc) begin
                r_idx <= w_idx_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_elem    <= w_in_elem;
            r_grade   <= w_grade_sat;
            r_courses <= w_courses_sat;
        end
        if (i_cmd.status_load) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.key_en) begin
            r_key <= KEY_W'(w_prod_grade) + KEY_W'(w_prod_courses);
        end
    end

    assign w_res_empty = (r_occ == '0);
    assign w_res_front = w_res_empty ? '0 : r_front;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= {3'b000, r_status, w_res_front.key, w_res_front.courses,
                      w_res_front.grade, w_res_front.element, r_occ, w_res_empty};
        end
    end

    assign o_out_data = r_out;

    assign o_sts.full     = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign o_sts.empty    = w_res_empty;
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.key_less = (r_rdata.key < r_key);
    assign o_sts.deq_end  = (r_idx >= r_occ);

    `WSPQ_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CNT_W'(QUEUE_DEPTH))
    `WSPQ_ASSERT_NOW(a_inc_not_full, i_clk, i_rst_n, i_cmd.occ_inc, !o_sts.full)
    `WSPQ_ASSERT_NOW(a_dec_not_empty, i_clk, i_rst_n, i_cmd.occ_dec, !o_sts.empty)
    `WSPQ_ASSERT_NOW(a_wr_in_range, i_clk, i_rst_n, i_cmd.wr_en, r_idx <= r_occ)

endmodule

### rtl/wspq_ctrl.sv
// sequencer for insertion walk, dequeue shift and result handoff
module wspq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    input  logic           i_out_ready,
    input  wspq_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output wspq_pkg::t_cmd o_cmd
);
    import wspq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_KEY    = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_DQ_PRE = 3'd3;
    localparam logic [2:0] S_DQ     = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_valid;
    logic       n_valid;
    logic       w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_out_ready;
        o_cmd   = '0;
        o_cmd.rd_mode = RD_IDX;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture     = 1'b1;
                    o_cmd.status_load = 1'b1;
                    o_cmd.status_code = ST_OK;
                    if (i_in_op == OP_ENQUEUE) begin
                        if (i_sts.full) begin
                            o_cmd.status_code = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_load_occ = 1'b1;
                            n_state = S_KEY;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            o_cmd.status_code = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_load_one = 1'b1;
                            n_state = S_DQ_PRE;
                        end
                    end
                end
            end
            S_KEY: begin
                o_cmd.key_en  = 1'b1;
                o_cmd.rd_mode = RD_IDX_M1;
                n_state = S_WALK;
            end
            S_WALK: begin
                // read data holds the slot just above the insertion point
                o_cmd.rd_mode = RD_IDX_M2;
                o_cmd.wr_en   = 1'b1;
                if (!i_sts.idx_zero && i_sts.key_less) begin
                    o_cmd.idx_dec = 1'b1;
                end else begin
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.occ_inc = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DQ_PRE: begin
                o_cmd.rd_mode = RD_IDX;
                n_state = S_DQ;
            end
            S_DQ: begin
                o_cmd.rd_mode = RD_IDX_P1;
                if (i_sts.deq_end) begin
                    o_cmd.occ_dec = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_down = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

### dv/weighted_sorted_priority_queue_top_tb.sv
// self-checking testbench of the weighted sorted priority queue top level
`timescale 1ns / 1ps

module weighted_sorted_priority_queue_top_tb;
    import wspq_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic                empty;
        logic [CNT_W-1:0]    count;
        logic [ELEM_W-1:0]   element;
        logic [GRADE_W-1:0]  grade;
        logic [COURSE_W-1:0] courses;
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] status;
    } t_front_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  s_op = OP_ENQUEUE;
    logic                  m_ready = 1'b1;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // queue contents as the block should hold them
    logic [ELEM_W-1:0]   held_element[QUEUE_DEPTH];
    logic [GRADE_W-1:0]  held_grade[QUEUE_DEPTH];
    logic [COURSE_W-1:0] held_courses[QUEUE_DEPTH];
    int unsigned         held_key[QUEUE_DEPTH];
    int                  held_count = 0;
    int unsigned         cur_grade_limit = 1000;
    int unsigned         cur_total = 30;

    t_front_report front_reports_due[$];
    int            mismatch_count = 0;
    int            stall_cycles = 0;
    int            ready_hold = 0;
    bit            pacing_on = 1'b0;

    weighted_sorted_priority_queue_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_op),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // sorted insertion behind equal keys, removal from the front
    task automatic predict_front_report(logic op, logic [ELEM_W-1:0] elem,
                                        logic [GRADE_W-1:0] grade,
                                        logic [COURSE_W-1:0] courses);
        t_front_report rep;
        int unsigned   g;
        int unsigned   c;
        int unsigned   key;
        int            pos;
        rep.status = ST_OK;
        if (op == OP_ENQUEUE) begin
            if (held_count >= QUEUE_DEPTH) begin
                rep.status = ST_FULL;
            end else begin
                g = (grade > cur_grade_limit) ? cur_grade_limit : grade;
                c = (courses > cur_total) ? cur_total : courses;
                key = g * cur_total + c * cur_grade_limit;
                pos = 0;
                while (pos < held_count && held_key[pos] >= key)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_element[i] = held_element[i-1];
                    held_grade[i]   = held_grade[i-1];
                    held_courses[i] = held_courses[i-1];
                    held_key[i]     = held_key[i-1];
                end
                held_element[pos] = elem;
                held_grade[pos]   = GRADE_W'(g);
                held_courses[pos] = COURSE_W'(c);
                held_key[pos]     = key;
                held_count++;
            end
        end else if (held_count == 0) begin
            rep.status = ST_EMPTY;
        end else begin
            for (int i = 1; i < held_count; i++) begin
                held_element[i-1] = held_element[i];
                held_grade[i-1]   = held_grade[i];
                held_courses[i-1] = held_courses[i];
                held_key[i-1]     = held_key[i];
            end
            held_count--;
        end
        rep.empty = (held_count == 0);
        rep.count = CNT_W'(held_count);
        if (held_count > 0) begin
            rep.element = held_element[0];
            rep.grade   = held_grade[0];
            rep.courses = held_courses[0];
            rep.key     = KEY_W'(held_key[0]);
        end else begin
            rep.element = '0;
            rep.grade   = '0;
            rep.courses = '0;
            rep.key     = '0;
        end
        front_reports_due.push_back(rep);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!pacing_on || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(logic op, logic [ELEM_W-1:0] elem,
                             logic [GRADE_W-1:0] grade, logic [COURSE_W-1:0] courses);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_op    = op;
        s_data  = {2'b00, courses, grade, elem};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predict_front_report(op, elem, grade, courses);
        @(negedge i_clk);
    endtask

    task automatic send_random_item(logic op, bit tie_mode);
        logic [ELEM_W-1:0]   elem;
        logic [GRADE_W-1:0]  grade;
        logic [COURSE_W-1:0] courses;
        int                  r;
        r = $urandom_range(0, 9);
        elem = (r == 0) ? '0 : (r == 1) ? '1 : ELEM_W'($urandom);
        r = $urandom_range(0, 9);
        if (tie_mode)
            grade = GRADE_W'((cur_grade_limit * $urandom_range(0, 2)) / 2);
        else if (r == 0)
            grade = '0;
        else if (r == 1)
            grade = GRADE_W'(10000);
        else if (r == 2)
            grade = GRADE_W'(cur_grade_limit);
        else if (r == 3)
            grade = GRADE_W'((cur_grade_limit < 10000) ? cur_grade_limit + 1 : 10000);
        else
            grade = GRADE_W'($urandom_range(0, 10000));
        r = $urandom_range(0, 9);
        if (tie_mode)
            courses = COURSE_W'((cur_total * $urandom_range(0, 2)) / 2);
        else if (r == 0)
            courses = '0;
        else if (r == 1)
            courses = '1;
        else if (r == 2)
            courses = COURSE_W'(cur_total);
        else
            courses = COURSE_W'($urandom_range(0, 255));
        send_item(op, elem, grade, courses);
    endtask

    task automatic wait_for_quiet();
        s_valid = 1'b0;
        while (front_reports_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = CFG_DATA_W'(value);
        if (idx == CFG_GRADE_LIMIT)
            cur_grade_limit = value;
        else
            cur_total = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_empty_and_ordering();
        pacing_on = 1'b1;
        send_item(OP_DEQUEUE, '0, '0, '0);
        send_item(OP_ENQUEUE, '0, '0, '0);
        // both fields saturate, lands in front of the zero key
        send_item(OP_ENQUEUE, '1, GRADE_W'(10000), COURSE_W'(255));
        // three equal keys must leave in arrival order
        send_item(OP_ENQUEUE, 32'h0000_00a1, GRADE_W'(500), COURSE_W'(15));
        send_item(OP_ENQUEUE, 32'h0000_00b2, GRADE_W'(1000), COURSE_W'(0));
        send_item(OP_ENQUEUE, 32'h0000_00c3, GRADE_W'(0), COURSE_W'(30));
        send_item(OP_DEQUEUE, '1, '1, '1);
    endtask

    task automatic test_fill_to_capacity();
        pacing_on = 1'b0;
        while (held_count < QUEUE_DEPTH)
            send_random_item(OP_ENQUEUE, 1'b0);
        send_random_item(OP_ENQUEUE, 1'b0);
    endtask

    // stored keys keep their old values after a register change
    task automatic test_register_update();
        wait_for_quiet();
        write_reg(CFG_GRADE_LIMIT, 1);
        write_reg(CFG_TOTAL, 1);
        pacing_on = 1'b1;
        send_item(OP_DEQUEUE, '0, '0, '0);
        send_item(OP_DEQUEUE, '0, '0, '0);
        send_item(OP_ENQUEUE, 32'h5a5a_a5a5, GRADE_W'(10000), COURSE_W'(255));
        send_item(OP_ENQUEUE, 32'ha5a5_5a5a, GRADE_W'(0), COURSE_W'(0));
    endtask

    task automatic test_random_traffic(int unsigned grade_limit, int unsigned total,
                                       int n_items);
        int  sent;
        int  shape;
        int  len;
        bit  tie_mode;
        wait_for_quiet();
        write_reg(CFG_GRADE_LIMIT, grade_limit);
        write_reg(CFG_TOTAL, total);
        sent = 0;
        while (sent < n_items) begin
            shape     = $urandom_range(0, 99);
            pacing_on = ($urandom_range(0, 3) != 0);
            tie_mode  = ($urandom_range(0, 3) == 0);
            len       = (shape < 70) ? $urandom_range(1, QUEUE_DEPTH + 3)
                                     : $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
                if (shape < 35)
                    send_random_item(OP_ENQUEUE, tie_mode);
                else if (shape < 70)
                    send_random_item(OP_DEQUEUE, tie_mode);
                else
                    send_random_item($urandom_range(0, 1), tie_mode);
            end
            sent += len;
        end
    endtask

    always @(negedge i_clk) begin : receiver_pacing
        int r;
        if (ready_hold != 0) begin
            ready_hold--;
        end else if (!pacing_on) begin
            m_ready = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_ready    = 1'b1;
                ready_hold = $urandom_range(0, 6);
            end else if (r < 92) begin
                m_ready    = 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                m_ready    = 1'b0;
                ready_hold = $urandom_range(10, 50);
            end
        end
    end

    function automatic void compare_field(string name, logic [31:0] due, logic [31:0] seen);
        if (due !== seen) begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, due, due, seen, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_front_report due;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (front_reports_due.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual 0x%0h",
                         $time, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                due = front_reports_due.pop_front();
                compare_field("queue_empty", due.empty, o_m_axis_tdata[0]);
                compare_field("entry_count", due.count, o_m_axis_tdata[5:1]);
                compare_field("front_element", due.element, o_m_axis_tdata[37:6]);
                compare_field("front_grade", due.grade, o_m_axis_tdata[51:38]);
                compare_field("front_courses", due.courses, o_m_axis_tdata[59:52]);
                compare_field("front_priority_key", due.key, o_m_axis_tdata[82:60]);
                compare_field("status", due.status, o_m_axis_tdata[84:83]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_and_ordering();
        test_fill_to_capacity();
        test_register_update();
        test_random_traffic(10000, 255, 240);
        test_random_traffic(1, 255, 240);
        test_random_traffic(10000, 1, 240);
        test_random_traffic($urandom_range(1, 10000), $urandom_range(1, 255), 240);
        test_random_traffic($urandom_range(1, 100), $urandom_range(1, 16), 240);
        test_random_traffic(1000, 30, 240);
        wait_for_quiet();
        repeat (25) @(negedge i_clk);
        if (mismatch_count == 0 && front_reports_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### weighted_sorted_priority_queue_top.f
+incdir+rtl
rtl/wspq_pkg.sv
rtl/wspq_datapath.sv
rtl/wspq_ctrl.sv
rtl/weighted_sorted_priority_queue_top.sv
dv/weighted_sorted_priority_queue_top_tb.sv
